// File: sv/amr_payload_deframer_assert.svh
// assertion macros for the amr payload deframer
`ifndef AMR_PAYLOAD_DEFRAMER_ASSERT_SVH
`define AMR_PAYLOAD_DEFRAMER_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define AMRDF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AMRDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/amrdf_pkg.sv
package amrdf_pkg;

  typedef enum logic [1:0] {
    PH_CMR,
    PH_TOC,
    PH_DATA,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    KIND_MODE_REQ = 2'd0,
    KIND_TOC      = 2'd1,
    KIND_SPEECH   = 2'd2,
    KIND_IGNORED  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  localparam logic [3:0] FT_MAX_SPEECH = 4'd7;

  // speech bits per frame for frame types 0..7
  localparam logic [7:0] FRAME_BITS [8] = '{
    8'd95, 8'd103, 8'd118, 8'd134, 8'd148, 8'd159, 8'd204, 8'd244
  };

  typedef struct packed {
    logic [5:0] index;
    logic [3:0] ftype;
    logic       q;
  } entry_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] mode_request;
    logic [5:0] frame_index;
    logic [3:0] frame_type;
    logic       quality;
    logic [7:0] data_byte;
    logic       frame_end;
    logic       packet_end;
    status_t    status;
  } result_t;

  // frame size in bytes, bits rounded up
  function automatic logic [4:0] frame_bytes(input logic [2:0] ft);
    logic [8:0] sum;
    sum = {1'b0, FRAME_BITS[ft]} + 9'd7;
    return sum[7:3];
  endfunction

endpackage

// File: sv/amr_payload_deframer.sv
// channel | handshake            | payload
// --------+----------------------+---------------------------------------------
// input   | in_valid / in_stall  | payload_byte, last_byte
// output  | out_valid / out_stall| kind, mode_request, frame_index, frame_type,
//         |                      | quality, data_byte, frame_end, packet_end,
//         |                      | status
// one byte per cycle while in_stall is low; each byte gives one registered result
// the table store read is registered and addressed by the next serve pointer,
// with write forwarding, so every byte is parsed in a single pass
// rst clears the parser state and both output slots; the table store is not
// cleared, only entries written in the current packet are read
// a skid slot behind the output register keeps input open while one result
// waits; in_stall rises only when both slots hold a result
`include "amr_payload_deframer_assert.svh"

module amr_payload_deframer #(
  parameter int MAX_FRAMES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] payload_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [3:0] mode_request,
  output logic [5:0] frame_index,
  output logic [3:0] frame_type,
  output logic       quality,
  output logic [7:0] data_byte,
  output logic       frame_end,
  output logic       packet_end,
  output logic [1:0] status
);

  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAMES);

  amrdf_pkg::phase_t phase, phase_next;
  logic [CW-1:0] entry_count, entry_count_next;
  logic [CW-1:0] data_count, data_count_next;
  logic [CW-1:0] serve_ptr, serve_ptr_next;
  logic [4:0]    byte_in_frame, byte_in_frame_next;

  amrdf_pkg::entry_t entry_mem [MAX_FRAMES];
  amrdf_pkg::entry_t rd_entry;
  amrdf_pkg::entry_t wr_entry;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;

  amrdf_pkg::result_t res, out_reg, skid_reg;
  logic               skid_valid;
  logic               accept;

  logic [CW+5:0] count_wide;
  logic [3:0]    toc_ft;
  logic [4:0]    bif_inc;
  logic [4:0]    cur_size;
  logic [CW-1:0] serve_inc;

  assign accept     = in_valid && !skid_valid;
  assign in_stall   = skid_valid;
  assign count_wide = {6'd0, entry_count};
  assign toc_ft     = payload_byte[6:3];
  assign bif_inc    = byte_in_frame + 5'd1;
  assign cur_size   = amrdf_pkg::frame_bytes(rd_entry.ftype[2:0]);
  assign serve_inc  = serve_ptr + CW'(1);

  // next state of the parser
  always_comb begin
    phase_next         = phase;
    entry_count_next   = entry_count;
    data_count_next    = data_count;
    serve_ptr_next     = serve_ptr;
    byte_in_frame_next = byte_in_frame;
    wr_en              = 1'b0;
    wr_addr            = data_count[AW-1:0];
    wr_entry.index     = count_wide[5:0];
    wr_entry.ftype     = toc_ft;
    wr_entry.q         = payload_byte[2];
    if (accept) begin
      unique case (phase)
        amrdf_pkg::PH_CMR: phase_next = amrdf_pkg::PH_TOC;
        amrdf_pkg::PH_TOC: begin
          if (entry_count < MAX_CNT) begin
            if (toc_ft <= amrdf_pkg::FT_MAX_SPEECH && data_count < MAX_CNT) begin
              wr_en           = 1'b1;
              data_count_next = data_count + CW'(1);
            end
            entry_count_next = entry_count + CW'(1);
          end
          if (!payload_byte[7]) begin
            serve_ptr_next     = '0;
            byte_in_frame_next = '0;
            phase_next = (data_count_next == '0) ? amrdf_pkg::PH_SKIP
                                                 : amrdf_pkg::PH_DATA;
          end
        end
        amrdf_pkg::PH_DATA: begin
          byte_in_frame_next = bif_inc;
          if (bif_inc >= cur_size) begin
            byte_in_frame_next = '0;
            serve_ptr_next     = serve_inc;
            if (serve_inc >= data_count) phase_next = amrdf_pkg::PH_SKIP;
          end
        end
        amrdf_pkg::PH_SKIP: phase_next = amrdf_pkg::PH_SKIP;
        default: phase_next = amrdf_pkg::PH_CMR;
      endcase
      if (last_byte) begin
        phase_next         = amrdf_pkg::PH_CMR;
        entry_count_next   = '0;
        data_count_next    = '0;
        serve_ptr_next     = '0;
        byte_in_frame_next = '0;
      end
    end
  end

  // result of the byte being taken
  always_comb begin
    logic done;
    done             = 1'b0;
    res.kind         = amrdf_pkg::KIND_IGNORED;
    res.mode_request = '0;
    res.frame_index  = '0;
    res.frame_type   = '0;
    res.quality      = 1'b0;
    res.data_byte    = '0;
    res.frame_end    = 1'b0;
    res.packet_end   = last_byte;
    res.status       = amrdf_pkg::ST_OK;
    unique case (phase)
      amrdf_pkg::PH_CMR: begin
        res.kind         = amrdf_pkg::KIND_MODE_REQ;
        res.mode_request = payload_byte[7:4];
      end
      amrdf_pkg::PH_TOC: begin
        res.kind        = amrdf_pkg::KIND_TOC;
        res.frame_index = count_wide[5:0];
        res.frame_type  = toc_ft;
        res.quality     = payload_byte[2];
        if (entry_count >= MAX_CNT) res.status = amrdf_pkg::ST_OVERFLOW;
        done = !payload_byte[7] && (data_count_next == '0);
      end
      amrdf_pkg::PH_DATA: begin
        res.kind        = amrdf_pkg::KIND_SPEECH;
        res.frame_index = rd_entry.index;
        res.frame_type  = rd_entry.ftype;
        res.quality     = rd_entry.q;
        res.data_byte   = payload_byte;
        if (bif_inc >= cur_size) begin
          res.frame_end = 1'b1;
          done          = (serve_inc >= data_count);
        end
      end
      amrdf_pkg::PH_SKIP: done = 1'b1;
      default: done = 1'b1;
    endcase
    if (last_byte && !done) res.status = amrdf_pkg::ST_TRUNCATED;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= amrdf_pkg::PH_CMR;
      entry_count   <= '0;
      data_count    <= '0;
      serve_ptr     <= '0;
      byte_in_frame <= '0;
    end else begin
      phase         <= phase_next;
      entry_count   <= entry_count_next;
      data_count    <= data_count_next;
      serve_ptr     <= serve_ptr_next;
      byte_in_frame <= byte_in_frame_next;
    end
  end

  // table store, read ahead at the next serve pointer with write forwarding
  assign rd_addr = serve_ptr_next[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) entry_mem[wr_addr] <= wr_entry;
    if (wr_en && wr_addr == rd_addr) rd_entry <= wr_entry;
    else rd_entry <= entry_mem[rd_addr];
  end

  // output register with skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) out_reg <= skid_reg;
      else if (accept) out_reg <= res;
    end else if (accept) begin
      skid_reg <= res;
    end
  end

  assign kind         = out_reg.kind;
  assign mode_request = out_reg.mode_request;
  assign frame_index  = out_reg.frame_index;
  assign frame_type   = out_reg.frame_type;
  assign quality      = out_reg.quality;
  assign data_byte    = out_reg.data_byte;
  assign frame_end    = out_reg.frame_end;
  assign packet_end   = out_reg.packet_end;
  assign status       = out_reg.status;

  `AMRDF_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid,
    "skid slot holds a result while the output register is empty")
  `AMRDF_ASSERT_NOW(a_serve_in_table, phase == amrdf_pkg::PH_DATA,
    serve_ptr < data_count, "serve pointer beyond the stored entries")
  `AMRDF_ASSERT_NOW(a_byte_in_frame, phase == amrdf_pkg::PH_DATA,
    byte_in_frame < cur_size, "byte position beyond the frame size")
  `AMRDF_ASSERT_NEXT(a_last_restarts, accept && last_byte,
    phase == amrdf_pkg::PH_CMR && entry_count == '0,
    "parser did not restart after the final byte")

endmodule
